[src/tvc_pkg.sv]
`timescale 1ns / 1ps

package tvc_pkg;

	// machine modes, as reported on machine_mode
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_SALE   = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_FARE_ONE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FARE_TWO   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FARE_THREE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BLINK      = 3'd4;
	localparam int unsigned CFG_DATA_W = 16;

	// register reset values
	localparam logic [9:0]  FARE_ONE_RST   = 10'd110;
	localparam logic [9:0]  FARE_TWO_RST   = 10'd120;
	localparam logic [9:0]  FARE_THREE_RST = 10'd125;
	localparam logic [15:0] TIMEOUT_RST    = 16'd6000;
	localparam logic [15:0] BLINK_RST      = 16'd100;

	// section codes in port bits 7..5
	localparam logic [2:0] SEC_CODE_ONE   = 3'b110;
	localparam logic [2:0] SEC_CODE_TWO   = 3'b101;
	localparam logic [2:0] SEC_CODE_THREE = 3'b011;

	localparam logic [1:0] SECTION_ONE   = 2'd1;
	localparam logic [1:0] SECTION_TWO   = 2'd2;
	localparam logic [1:0] SECTION_THREE = 2'd3;

	// one-hot coin codes in port bits 4..0
	localparam logic [4:0] COIN_5   = 5'h01;
	localparam logic [4:0] COIN_10  = 5'h02;
	localparam logic [4:0] COIN_25  = 5'h04;
	localparam logic [4:0] COIN_50  = 5'h08;
	localparam logic [4:0] COIN_100 = 5'h10;

	localparam logic [6:0] CHANGE_MAX = 7'd99;

	typedef struct packed {
		logic [9:0]  fare_one;
		logic [9:0]  fare_two;
		logic [9:0]  fare_three;
		logic [15:0] timeout;
		logic [15:0] blink;
	} cfg_t;

	typedef struct packed {
		logic        issued;
		logic [15:0] ticket_number;
		logic [6:0]  change;
		logic [1:0]  section;
		logic        led;
		logic [1:0]  mode;
	} result_t;

	function automatic logic [1:0] decode_section(input logic [7:0] port);
		logic [1:0] sec;
		unique case (port[7:5])
			SEC_CODE_ONE:   sec = SECTION_ONE;
			SEC_CODE_TWO:   sec = SECTION_TWO;
			SEC_CODE_THREE: sec = SECTION_THREE;
			default:        sec = SECTION_ONE;
		endcase
		return sec;
	endfunction

	// a code that is not one-hot is worth nothing
	function automatic logic [6:0] decode_coin(input logic [7:0] port);
		logic [6:0] val;
		unique case (port[4:0])
			COIN_5:   val = 7'd5;
			COIN_10:  val = 7'd10;
			COIN_25:  val = 7'd25;
			COIN_50:  val = 7'd50;
			COIN_100: val = 7'd100;
			default:  val = 7'd0;
		endcase
		return val;
	endfunction

endpackage

[src/tvc_cfg_regs.sv]
`timescale 1ns / 1ps

module tvc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tvc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tvc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output tvc_pkg::cfg_t                     cfg
);

	tvc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fare_one   <= tvc_pkg::FARE_ONE_RST;
			cfg_q.fare_two   <= tvc_pkg::FARE_TWO_RST;
			cfg_q.fare_three <= tvc_pkg::FARE_THREE_RST;
			cfg_q.timeout    <= tvc_pkg::TIMEOUT_RST;
			cfg_q.blink      <= tvc_pkg::BLINK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tvc_pkg::REG_FARE_ONE:   cfg_q.fare_one   <= cfg_data[9:0];
				tvc_pkg::REG_FARE_TWO:   cfg_q.fare_two   <= cfg_data[9:0];
				tvc_pkg::REG_FARE_THREE: cfg_q.fare_three <= cfg_data[9:0];
				tvc_pkg::REG_TIMEOUT:    cfg_q.timeout    <= cfg_data;
				tvc_pkg::REG_BLINK:      cfg_q.blink      <= cfg_data;
				default: ; // unmapped index, dropped
			endcase
		end
	end

endmodule

[src/tvc_core.sv]
`timescale 1ns / 1ps

module tvc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             sale_request,
	input  logic             coin_inserted,
	input  logic [7:0]       port_value,
	input  logic             restock_button,
	input  tvc_pkg::cfg_t    cfg,
	output tvc_pkg::result_t res
);

	logic [1:0]  mode_q,     mode_d;
	logic [1:0]  section_q,  section_d;
	logic [10:0] money_q,    money_d;
	logic [15:0] timer_q,    timer_d;
	logic [15:0] count_q,    count_d;
	logic        led_q,      led_d;
	logic        sale_pend_q, sale_pend_d;
	logic        coin_pend_q, coin_pend_d;

	logic        issued;
	logic [6:0]  change;
	logic [15:0] timer_inc;
	logic [9:0]  fare;
	logic [10:0] money_sum;
	logic [10:0] diff;

	assign timer_inc = timer_q + 16'd1;
	assign money_sum = money_q + {4'd0, tvc_pkg::decode_coin(port_value)};
	assign diff      = money_sum - {1'b0, fare};

	always_comb begin
		unique case (section_q)
			tvc_pkg::SECTION_TWO:   fare = cfg.fare_two;
			tvc_pkg::SECTION_THREE: fare = cfg.fare_three;
			default:                fare = cfg.fare_one;
		endcase
	end

	always_comb begin
		mode_d      = mode_q;
		section_d   = section_q;
		money_d     = money_q;
		timer_d     = timer_q;
		count_d     = count_q;
		led_d       = led_q;
		sale_pend_d = sale_pend_q | sale_request;
		coin_pend_d = coin_pend_q | coin_inserted;
		issued      = 1'b0;
		change      = 7'd0;
		unique case (mode_q)
			tvc_pkg::MODE_SALE: begin
				timer_d = timer_inc;
				if (timer_inc == cfg.timeout) begin
					money_d = 11'd0;
					mode_d  = tvc_pkg::MODE_CANCEL;
					timer_d = 16'd0;
				end else if (coin_pend_d) begin
					coin_pend_d = 1'b0;
					money_d     = money_sum;
					if (money_sum >= {1'b0, fare}) begin
						count_d = count_q + 16'd1;
						led_d   = 1'b1;
						mode_d  = tvc_pkg::MODE_IDLE;
						issued  = 1'b1;
						change  = (diff > {4'd0, tvc_pkg::CHANGE_MAX}) ?
							tvc_pkg::CHANGE_MAX : diff[6:0];
					end
				end
			end
			tvc_pkg::MODE_CANCEL: begin
				timer_d = timer_inc;
				if (!restock_button) begin
					mode_d = tvc_pkg::MODE_IDLE;
					led_d  = 1'b1;
				end else if (timer_inc == cfg.blink) begin
					timer_d = 16'd0;
					led_d   = ~led_q;
				end
			end
			default: begin
				// idle
				if (sale_pend_d) begin
					sale_pend_d = 1'b0;
					led_d       = 1'b0;
					section_d   = tvc_pkg::decode_section(port_value);
					mode_d      = tvc_pkg::MODE_SALE;
					money_d     = 11'd0;
					timer_d     = 16'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tvc_pkg::MODE_IDLE;
			section_q   <= tvc_pkg::SECTION_ONE;
			money_q     <= 11'd0;
			timer_q     <= 16'd0;
			count_q     <= 16'd0;
			led_q       <= 1'b1;
			sale_pend_q <= 1'b0;
			coin_pend_q <= 1'b0;
		end else if (step) begin
			mode_q      <= mode_d;
			section_q   <= section_d;
			money_q     <= money_d;
			timer_q     <= timer_d;
			count_q     <= count_d;
			led_q       <= led_d;
			sale_pend_q <= sale_pend_d;
			coin_pend_q <= coin_pend_d;
		end
	end

	// result carries the values after this tick's update
	assign res.issued        = issued;
	assign res.ticket_number = count_d;
	assign res.change        = change;
	assign res.section       = section_d;
	assign res.led           = led_d;
	assign res.mode          = mode_d;

endmodule

[src/ticket_vending_controller.sv]
`timescale 1ns / 1ps

// Ticket vending controller: one input word per 100 ms tick, one result word back.
// Input channel: in_valid/in_stall carry sale_request, coin_inserted, port_value
//   (section code in bits 7..5, one-hot coin in bits 4..0) and restock_button
//   (active low). A word is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall carry ticket_issued, ticket_number,
//   change_cents, selected_section, led_pin (0 = lit) and machine_mode.
// Config channel: cfg_valid/cfg_ready with cfg_index 0..4 (fares one to three,
//   sale timeout, blink period); cfg_ready is always high, other indexes dropped.
//   Write it only while no word is in flight.
// Path: an accepted word goes into the input register, then through the mode
//   update into the result register. Throughput: one word per cycle while
//   out_stall is low, set by the combinational state update between those two registers.
// Stalls: a held result keeps its word on the output; the input register
//   still takes a word while the result register is empty or draining, so
//   in_stall only rises when both registers are full and out_stall is high.
// Reset (arst_n low): mode idle, section one, LED off, counters and pending
//   flags clear, registers back to their default fares and periods.

module ticket_vending_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            sale_request,
	input  logic                            coin_inserted,
	input  logic [7:0]                      port_value,
	input  logic                            restock_button,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            ticket_issued,
	output logic [15:0]                     ticket_number,
	output logic [6:0]                      change_cents,
	output logic [1:0]                      selected_section,
	output logic                            led_pin,
	output logic [1:0]                      machine_mode,
	// config channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tvc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tvc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	tvc_pkg::cfg_t    cfg;
	tvc_pkg::result_t res;
	tvc_pkg::result_t res_q;

	// input register
	logic       valid_s1;
	logic       sale_s1;
	logic       coin_s1;
	logic [7:0] port_s1;
	logic       restock_s1;

	logic       out_valid_q;
	logic       advance;
	logic       step;

	// result register can take a word when empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sale_s1    <= sale_request;
			coin_s1    <= coin_inserted;
			port_s1    <= port_value;
			restock_s1 <= restock_button;
		end
	end

	tvc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// mode machine; its state moves only when a word goes to the result register
	tvc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.sale_request   (sale_s1),
		.coin_inserted  (coin_s1),
		.port_value     (port_s1),
		.restock_button (restock_s1),
		.cfg            (cfg),
		.res            (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign ticket_issued    = res_q.issued;
	assign ticket_number    = res_q.ticket_number;
	assign change_cents     = res_q.change;
	assign selected_section = res_q.section;
	assign led_pin          = res_q.led;
	assign machine_mode     = res_q.mode;

endmodule

[verif/ticket_vending_controller_test.sv]
`timescale 1ns / 1ps

// Predicts the result word for every accepted input word and holds the
// results still owed by the block, oldest first.
class ticket_ledger;
	tvc_pkg::cfg_t    regs;
	logic [1:0]       mode;
	logic [1:0]       section;
	logic [10:0]      money;
	logic [15:0]      tick_timer;
	logic [15:0]      tickets;
	logic             led;
	logic             sale_flag;
	logic             coin_flag;
	tvc_pkg::result_t owed[$];
	int               faults;

	function new();
		regs.fare_one   = tvc_pkg::FARE_ONE_RST;
		regs.fare_two   = tvc_pkg::FARE_TWO_RST;
		regs.fare_three = tvc_pkg::FARE_THREE_RST;
		regs.timeout    = tvc_pkg::TIMEOUT_RST;
		regs.blink      = tvc_pkg::BLINK_RST;
		mode       = tvc_pkg::MODE_IDLE;
		section    = tvc_pkg::SECTION_ONE;
		money      = '0;
		tick_timer = '0;
		tickets    = '0;
		led        = 1'b1;
		sale_flag  = 1'b0;
		coin_flag  = 1'b0;
		faults     = 0;
	endfunction

	function void write_reg(logic [tvc_pkg::CFG_INDEX_W-1:0] index,
			logic [tvc_pkg::CFG_DATA_W-1:0] data);
		case (index)
			tvc_pkg::REG_FARE_ONE:   regs.fare_one   = data[9:0];
			tvc_pkg::REG_FARE_TWO:   regs.fare_two   = data[9:0];
			tvc_pkg::REG_FARE_THREE: regs.fare_three = data[9:0];
			tvc_pkg::REG_TIMEOUT:    regs.timeout    = data;
			tvc_pkg::REG_BLINK:      regs.blink      = data;
			default: ;
		endcase
	endfunction

	function logic [1:0] port_section(logic [2:0] code);
		case (code)
			tvc_pkg::SEC_CODE_TWO:   return tvc_pkg::SECTION_TWO;
			tvc_pkg::SEC_CODE_THREE: return tvc_pkg::SECTION_THREE;
			default:                 return tvc_pkg::SECTION_ONE;
		endcase
	endfunction

	function logic [6:0] coin_cents(logic [4:0] code);
		case (code)
			tvc_pkg::COIN_5:   return 7'd5;
			tvc_pkg::COIN_10:  return 7'd10;
			tvc_pkg::COIN_25:  return 7'd25;
			tvc_pkg::COIN_50:  return 7'd50;
			tvc_pkg::COIN_100: return 7'd100;
			default:           return 7'd0;
		endcase
	endfunction

	function logic [9:0] fare_due();
		case (section)
			tvc_pkg::SECTION_TWO:   return regs.fare_two;
			tvc_pkg::SECTION_THREE: return regs.fare_three;
			default:                return regs.fare_one;
		endcase
	endfunction

	function void take_word(logic sale, logic coin, logic [7:0] port, logic restock);
		tvc_pkg::result_t r;
		logic [9:0]       fare;
		logic [10:0]      over;
		r = '0;
		if (sale)
			sale_flag = 1'b1;
		if (coin)
			coin_flag = 1'b1;
		case (mode)
			tvc_pkg::MODE_IDLE: begin
				if (sale_flag) begin
					sale_flag  = 1'b0;
					led        = 1'b0;
					section    = port_section(port[7:5]);
					mode       = tvc_pkg::MODE_SALE;
					money      = '0;
					tick_timer = '0;
				end
			end
			tvc_pkg::MODE_SALE: begin
				tick_timer = tick_timer + 16'd1;
				if (tick_timer == regs.timeout) begin
					money      = '0;
					mode       = tvc_pkg::MODE_CANCEL;
					tick_timer = '0;
				end else if (coin_flag) begin
					fare      = fare_due();
					coin_flag = 1'b0;
					money     = money + coin_cents(port[4:0]);
					if (money >= fare) begin
						tickets  = tickets + 16'd1;
						led      = 1'b1;
						mode     = tvc_pkg::MODE_IDLE;
						r.issued = 1'b1;
						over     = money - fare;
						r.change = (over > 11'd99) ? tvc_pkg::CHANGE_MAX : over[6:0];
					end
				end
			end
			default: begin
				tick_timer = tick_timer + 16'd1;
				if (!restock) begin
					mode = tvc_pkg::MODE_IDLE;
					led  = 1'b1;
				end else if (tick_timer == regs.blink) begin
					tick_timer = '0;
					led        = ~led;
				end
			end
		endcase
		r.ticket_number = tickets;
		r.section       = section;
		r.led           = led;
		r.mode          = mode;
		owed.push_back(r);
	endfunction

	function void compare(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			faults++;
		end
	endfunction

	function void match_result(tvc_pkg::result_t got);
		tvc_pkg::result_t want;
		if (owed.size() == 0) begin
			$display("%0t ns: result word arrived with none owed", $time);
			faults++;
			return;
		end
		want = owed.pop_front();
		compare("ticket_issued", want.issued, got.issued);
		compare("ticket_number", want.ticket_number, got.ticket_number);
		compare("change_cents", want.change, got.change);
		compare("selected_section", want.section, got.section);
		compare("led_pin", want.led, got.led);
		compare("machine_mode", want.mode, got.mode);
	endfunction
endclass

// Ticket vending controller bench.
// Words go in through in_valid/in_stall and come back one for one through
// out_valid/out_stall; the ledger above predicts each result word from the
// accepted input word and checks the returned word field by field.
// Registers are only rewritten once every owed result has come back.
module ticket_vending_controller_test;

	localparam int HOLD_CYCLES = 150;	// long receiver hold-off, fills both stages
	localparam int PHASE_WORDS = 240;

	logic                            clk            = 1'b0;
	logic                            arst_n         = 1'b0;
	logic                            in_valid       = 1'b0;
	logic                            in_stall;
	logic                            sale_request   = 1'b0;
	logic                            coin_inserted  = 1'b0;
	logic [7:0]                      port_value     = 8'h00;
	logic                            restock_button = 1'b1;
	logic                            out_valid;
	logic                            out_stall      = 1'b0;
	logic                            ticket_issued;
	logic [15:0]                     ticket_number;
	logic [6:0]                      change_cents;
	logic [1:0]                      selected_section;
	logic                            led_pin;
	logic [1:0]                      machine_mode;
	logic                            cfg_valid      = 1'b0;
	logic                            cfg_ready;
	logic [tvc_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
	logic [tvc_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;

	ticket_ledger ledger = new();

	int words_sent   = 0;
	int burst_left   = 0;
	int hold_asked   = 0;	// bumped by the stimulus, served by the stall process
	int hold_granted = 0;

	ticket_vending_controller dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sale_request     (sale_request),
		.coin_inserted    (coin_inserted),
		.port_value       (port_value),
		.restock_button   (restock_button),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.ticket_issued    (ticket_issued),
		.ticket_number    (ticket_number),
		.change_cents     (change_cents),
		.selected_section (selected_section),
		.led_pin          (led_pin),
		.machine_mode     (machine_mode),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Monitor: everything is sampled at the edge, before this edge's updates land.
	always @(posedge clk) begin
		tvc_pkg::result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				ledger.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				ledger.take_word(sale_request, coin_inserted, port_value, restock_button);
			if (out_valid && !out_stall) begin
				got = {ticket_issued, ticket_number, change_cents, selected_section,
					led_pin, machine_mode};
				ledger.match_result(got);
			end
		end
	end

	// Receiver back-pressure: segments of random length, each with its own
	// style (none, light random, periodic, heavy random), plus long hold-offs
	// on request.
	initial begin : stall_pattern
		int style;
		int span;
		int period;
		int duty;
		forever begin
			if (hold_asked != hold_granted) begin
				hold_granted++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				style  = $urandom_range(0, 3);
				span   = $urandom_range(8, 120);
				period = $urandom_range(2, 7);
				duty   = $urandom_range(1, period - 1);
				for (int i = 0; i < span; i++) begin
					case (style)
						0:       out_stall <= 1'b0;
						1:       out_stall <= ($urandom_range(0, 99) < 20);
						2:       out_stall <= ((i % period) < duty);
						default: out_stall <= ($urandom_range(0, 99) < 70);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// One word per call; bursts of random length with random gaps, gap of
	// zero keeps valid high straight through.
	task automatic send_word(input logic sale, input logic coin, input logic [7:0] port,
			input logic restock);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid       <= 1'b1;
		sale_request   <= sale;
		coin_inserted  <= coin;
		port_value     <= port;
		restock_button <= restock;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
	endtask

	// Sender stops and waits for every owed result.
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		// let a word taken at this edge reach the ledger before the owed check
		@(posedge clk);
		while (ledger.owed.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [tvc_pkg::CFG_INDEX_W-1:0] index,
			input logic [tvc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic set_config(input logic [9:0] fare_one, input logic [9:0] fare_two,
			input logic [9:0] fare_three, input logic [15:0] timeout,
			input logic [15:0] blink);
		drain();
		write_reg(tvc_pkg::REG_FARE_ONE, {6'd0, fare_one});
		write_reg(tvc_pkg::REG_FARE_TWO, {6'd0, fare_two});
		write_reg(tvc_pkg::REG_FARE_THREE, {6'd0, fare_three});
		write_reg(tvc_pkg::REG_TIMEOUT, timeout);
		write_reg(tvc_pkg::REG_BLINK, blink);
		cfg_valid <= 1'b0;
	endtask

	// Mostly real section codes, now and then an unknown one.
	function automatic logic [2:0] pick_code();
		case ($urandom_range(0, 3))
			0:       return tvc_pkg::SEC_CODE_ONE;
			1:       return tvc_pkg::SEC_CODE_TWO;
			2:       return tvc_pkg::SEC_CODE_THREE;
			default: return 3'($urandom);
		endcase
	endfunction

	function automatic logic [4:0] pick_coin();
		case ($urandom_range(0, 4))
			0:       return tvc_pkg::COIN_5;
			1:       return tvc_pkg::COIN_10;
			2:       return tvc_pkg::COIN_25;
			3:       return tvc_pkg::COIN_50;
			default: return tvc_pkg::COIN_100;
		endcase
	endfunction

	// A proper sale: request, then a run of coins with the odd bad code,
	// empty tick or restock press mixed in.
	task automatic sale_run();
		int coins;
		int pick;
		coins = $urandom_range(1, 30);
		send_word(1'b1, ($urandom_range(0, 9) == 0), {pick_code(), 5'($urandom)}, 1'b1);
		for (int i = 0; i < coins; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				send_word(1'b0, 1'b1, {3'($urandom), pick_coin()},
					($urandom_range(0, 19) != 0));
			else if (pick < 90)
				send_word(1'b0, 1'b1, 8'($urandom), 1'b1);
			else
				send_word(1'b0, 1'b0, 8'($urandom), 1'b1);
		end
	endtask

	// Empty ticks to run the sale timer out and blink the LED, usually
	// closed by a restock press.
	task automatic idle_run();
		int ticks;
		ticks = $urandom_range(1, 40);
		repeat (ticks)
			send_word(1'b0, 1'b0, 8'($urandom), 1'b1);
		if ($urandom_range(0, 9) < 7)
			send_word(1'b0, 1'b0, 8'($urandom), 1'b0);
	endtask

	task automatic noise_run();
		int n;
		n = $urandom_range(1, 10);
		repeat (n)
			send_word(1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic run_phase(input int count);
		int goal;
		int pick;
		goal = words_sent + count;
		while (words_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				sale_run();
			else if (pick < 80)
				idle_run();
			else
				noise_run();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default fares, short timeout and blink period.
		set_config(tvc_pkg::FARE_ONE_RST, tvc_pkg::FARE_TWO_RST,
			tvc_pkg::FARE_THREE_RST, 16'd6, 16'd2);
		// coin while idle stays pending
		send_word(1'b0, 1'b1, {3'b000, tvc_pkg::COIN_100}, 1'b1);
		// sale, section one
		send_word(1'b1, 1'b0, {tvc_pkg::SEC_CODE_ONE, 5'h00}, 1'b1);
		// pending coin taken now
		send_word(1'b0, 1'b0, {3'b000, tvc_pkg::COIN_5}, 1'b1);
		send_word(1'b0, 1'b1, {3'b111, tvc_pkg::COIN_100}, 1'b1);
		// ticket with change
		send_word(1'b0, 1'b1, {3'b000, tvc_pkg::COIN_10}, 1'b1);
		// sale and coin together
		send_word(1'b1, 1'b1, {tvc_pkg::SEC_CODE_TWO, tvc_pkg::COIN_50}, 1'b1);
		// not one-hot, worth nothing
		send_word(1'b0, 1'b0, {tvc_pkg::SEC_CODE_TWO, 5'h1f}, 1'b1);
		// sale flag mid-sale waits
		send_word(1'b1, 1'b1, {3'b000, tvc_pkg::COIN_50}, 1'b1);
		send_word(1'b0, 1'b1, {3'b000, tvc_pkg::COIN_25}, 1'b1);
		send_word(1'b0, 1'b0, 8'h00, 1'b1);
		send_word(1'b0, 1'b1, 8'h00, 1'b1);			// empty coin code
		// timeout beats the coin
		send_word(1'b0, 1'b1, {3'b000, tvc_pkg::COIN_100}, 1'b1);
		repeat (4)
			send_word(1'b0, 1'b0, 8'h00, 1'b1);		// LED blinks
		send_word(1'b0, 1'b0, 8'hff, 1'b0);			// restock, back to idle
		// waiting sale flag starts
		send_word(1'b0, 1'b0, {tvc_pkg::SEC_CODE_THREE, 5'h00}, 1'b1);
		// waiting coin flag
		send_word(1'b0, 1'b0, {3'b000, tvc_pkg::COIN_100}, 1'b1);
		// exact fare, no change
		send_word(1'b0, 1'b1, {3'b000, tvc_pkg::COIN_25}, 1'b1);
		send_word(1'b1, 1'b0, 8'hff, 1'b1);			// unknown code, section one
		send_word(1'b0, 1'b1, 8'hff, 1'b1);
		// restock ignored mid-sale
		send_word(1'b0, 1'b1, {3'b000, tvc_pkg::COIN_100}, 1'b0);
		send_word(1'b0, 1'b1, {3'b000, tvc_pkg::COIN_100}, 1'b1);

		// Random phases, each under its own register setting.
		set_config(10'd5, 10'd10, 10'd25, 16'd8, 16'd1);
		hold_asked++;
		run_phase(PHASE_WORDS);
		// zero fare saturates the change; widest fare and longest timers
		set_config(10'd0, 10'd1023, 10'd1, 16'd65535, 16'd65535);
		run_phase(PHASE_WORDS);
		set_config(10'd1000, 10'd999, 10'd500, 16'd30, 16'd3);
		run_phase(PHASE_WORDS);
		set_config(tvc_pkg::FARE_ONE_RST, tvc_pkg::FARE_TWO_RST, tvc_pkg::FARE_THREE_RST,
			tvc_pkg::TIMEOUT_RST, tvc_pkg::BLINK_RST);
		hold_asked++;
		run_phase(PHASE_WORDS);
		repeat (4) begin
			set_config(10'($urandom_range(1, 300)), 10'($urandom_range(1, 300)),
				10'($urandom_range(1, 300)), 16'($urandom_range(4, 60)),
				16'($urandom_range(1, 12)));
			run_phase(PHASE_WORDS);
		end

		drain();
		repeat (8) @(posedge clk);	// catch any stray result word
		if (ledger.faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest legitimate run.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
